// ----- src/gesture_grid_template_match_macros.svh -----
// Assertion helpers for the checker file.
`ifndef GESTURE_GRID_TEMPLATE_MATCH_MACROS_SVH
`define GESTURE_GRID_TEMPLATE_MATCH_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define GGTM_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define GGTM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- src/ggtm_pkg.sv -----
package ggtm_pkg;

    localparam int GRID_SIDE     = 10;
    localparam int GRID_CELLS    = GRID_SIDE * GRID_SIDE;
    localparam int GRID_ROW_W    = $clog2(GRID_SIDE);
    localparam int POOL_SIDE     = GRID_SIDE / 2;
    localparam int POOL_CELLS    = POOL_SIDE * POOL_SIDE;
    localparam int POOL_IDX_W    = $clog2(POOL_CELLS);
    localparam int POOL_COL_W    = $clog2(POOL_SIDE);

    localparam int COORD_BITS_DEF = 12;
    localparam int CANVAS_W       = 12;
    localparam int TEMPLATE_W     = 25;
    localparam int CFG_DATA_W     = 25;

    localparam logic [CANVAS_W-1:0]   CANVAS_RST   = 12'd1024;
    localparam logic [TEMPLATE_W-1:0] TEMPLATE_RST = 25'd4330464;

    localparam int SCORE_W   = 10;
    localparam int MATCH_W   = 5;
    localparam int PENALTY_W = 6;
    localparam int OUT_W     = 24;   // 21 payload bits padded to bytes

    localparam logic [PENALTY_W-1:0] BASE_PENALTY = 6'd8;

    // restoring division step counts
    localparam int MAP_STEPS   = 4;  // grid coordinate quotient < 16
    localparam int SCORE_STEPS = SCORE_W;
    localparam int CNT_W       = 5;

    typedef enum logic [0:0] {
        CFG_CANVAS   = 1'b0,
        CFG_TEMPLATE = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAP,
        S_MARK,
        S_POOL,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic map_step;
        logic mark;
        logic pool_init;
        logic pool_step;
        logic div_load;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic last;
        logic out_valid;
    } t_sts;

endpackage

// ----- src/ggtm_ctrl.sv -----
module ggtm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ggtm_pkg::t_sts i_sts,
    output ggtm_pkg::t_cmd o_cmd
);
    import ggtm_pkg::*;

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // next state and step counter
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt + CNT_W'(1);
        unique case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (i_in_valid) n_state = S_MAP;
            end
            S_MAP: begin
                if (r_cnt == CNT_W'(MAP_STEPS - 1)) begin
                    n_state = S_MARK;
                    n_cnt   = '0;
                end
            end
            S_MARK: begin
                n_cnt   = '0;
                n_state = i_sts.last ? S_POOL : S_IDLE;
            end
            S_POOL: begin
                if (r_cnt == CNT_W'(POOL_CELLS - 1)) begin
                    n_state = S_DIV;
                    n_cnt   = '0;
                end
            end
            S_DIV: begin
                if (r_cnt == CNT_W'(SCORE_STEPS)) begin
                    n_state = S_DONE;
                    n_cnt   = '0;
                end
            end
            S_DONE: begin
                n_cnt = '0;
                if (!i_sts.out_valid) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
                n_cnt   = '0;
            end
        endcase
    end

    // commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_MAP:  o_cmd.map_step = 1'b1;
            S_MARK: begin
                o_cmd.mark      = 1'b1;
                o_cmd.pool_init = i_sts.last;
            end
            S_POOL: o_cmd.pool_step = 1'b1;
            S_DIV: begin
                o_cmd.div_load = (r_cnt == '0);
                o_cmd.div_step = (r_cnt != '0);
            end
            S_DONE: o_cmd.out_load = !i_sts.out_valid;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ----- src/ggtm_dp.sv -----
module ggtm_dp #(
    parameter int COORD_BITS = ggtm_pkg::COORD_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [0:0]                     i_cfg_addr,
    input  logic [ggtm_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic [COORD_BITS-1:0]          i_x_pos,
    input  logic [COORD_BITS-1:0]          i_y_pos,
    input  logic                           i_last_point,
    input  ggtm_pkg::t_cmd                 i_cmd,
    output ggtm_pkg::t_sts                 o_sts,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [ggtm_pkg::SCORE_W-1:0]   o_score_q8,
    output logic [ggtm_pkg::MATCH_W-1:0]   o_match_count,
    output logic [ggtm_pkg::PENALTY_W-1:0] o_penalty_count
);
    import ggtm_pkg::*;

    localparam int NW = COORD_BITS + 4;   // holds 10 * coordinate
    localparam int DW = COORD_BITS + 3;   // canvas << 3
    localparam int QW = MATCH_W + 8;      // match << 8
    localparam int SW = PENALTY_W + SCORE_W - 1; // penalty << 9

    // configuration
    logic [CANVAS_W-1:0]   r_canvas;
    logic [TEMPLATE_W-1:0] r_template;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_canvas   <= CANVAS_RST;
            r_template <= TEMPLATE_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_addr))
                CFG_CANVAS:   r_canvas   <= i_cfg_wdata[CANVAS_W-1:0];
                CFG_TEMPLATE: r_template <= i_cfg_wdata[TEMPLATE_W-1:0];
                default:      r_canvas   <= r_canvas;
            endcase
        end
    end

    // point to grid cell: two 4-step restoring dividers
    logic [COORD_BITS-1:0] w_canvas;
    logic [COORD_BITS-1:0] w_flip;
    logic                  w_in_range;
    logic [NW-1:0]         r_rem_c, r_rem_r;
    logic [DW-1:0]         r_dvs;
    logic [MAP_STEPS-1:0]  r_qc, r_qr;
    logic                  r_in_range, r_last;
    logic                  w_ge_c, w_ge_r;

    assign w_canvas   = COORD_BITS'(r_canvas);
    assign w_flip     = w_canvas - i_y_pos;
    // column < side iff x < w; row < side iff 0 < y <= w
    assign w_in_range = (w_canvas != '0) && (i_x_pos < w_canvas) &&
                        (i_y_pos != '0) && (i_y_pos <= w_canvas);
    assign w_ge_c     = (r_rem_c >= NW'(r_dvs));
    assign w_ge_r     = (r_rem_r >= NW'(r_dvs));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem_c    <= (NW'(i_x_pos) << 3) + (NW'(i_x_pos) << 1);
            r_rem_r    <= (NW'(w_flip) << 3) + (NW'(w_flip) << 1);
            r_dvs      <= DW'(w_canvas) << 3;
            r_qc       <= '0;
            r_qr       <= '0;
            r_in_range <= w_in_range;
            r_last     <= i_last_point;
        end else if (i_cmd.map_step) begin
            if (w_ge_c) r_rem_c <= r_rem_c - NW'(r_dvs);
            if (w_ge_r) r_rem_r <= r_rem_r - NW'(r_dvs);
            r_qc  <= {r_qc[MAP_STEPS-2:0], w_ge_c};
            r_qr  <= {r_qr[MAP_STEPS-2:0], w_ge_r};
            r_dvs <= r_dvs >> 1;
        end
    end

    // occupancy grid, one word per row, one bit per column
    logic [GRID_SIDE-1:0] r_grid [GRID_SIDE];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < GRID_SIDE; i++) begin
                r_grid[i] <= '0;
            end
        end else if (i_cmd.out_load) begin
            for (int i = 0; i < GRID_SIDE; i++) begin
                r_grid[i] <= '0;
            end
        end else if (i_cmd.mark && r_in_range) begin
            r_grid[r_qr][r_qc] <= 1'b1;
        end
    end

    // pooling walk: one 2x2 block per cycle
    logic [POOL_COL_W-1:0] r_pr;
    logic [POOL_IDX_W-1:0] r_tidx;
    logic [POOL_COL_W-1:0] r_pc;
    logic [MATCH_W-1:0]    r_match;
    logic [PENALTY_W-1:0]  r_pen;
    logic [GRID_ROW_W-1:0] w_row0, w_row1, w_col0, w_col1;
    logic [GRID_SIDE-1:0]  w_top, w_bot;
    logic                  w_g, w_t;

    assign w_row0 = GRID_ROW_W'({r_pr, 1'b0});
    assign w_row1 = GRID_ROW_W'({r_pr, 1'b1});
    assign w_col0 = GRID_ROW_W'({r_pc, 1'b0});
    assign w_col1 = GRID_ROW_W'({r_pc, 1'b1});
    assign w_top  = r_grid[w_row0];
    assign w_bot  = r_grid[w_row1];
    assign w_g    = w_top[w_col0] | w_top[w_col1] | w_bot[w_col0] | w_bot[w_col1];
    assign w_t    = r_template[r_tidx];

    always_ff @(posedge i_clk) begin
        if (i_cmd.pool_init) begin
            r_pr    <= '0;
            r_tidx  <= '0;
            r_pc    <= '0;
            r_match <= '0;
            r_pen   <= BASE_PENALTY;
        end else if (i_cmd.pool_step) begin
            r_tidx <= r_tidx + POOL_IDX_W'(1);
            if (r_pc == POOL_COL_W'(POOL_SIDE - 1)) begin
                r_pc <= '0;
                r_pr <= r_pr + POOL_COL_W'(1);
            end else begin
                r_pc <= r_pc + POOL_COL_W'(1);
            end
            if (w_g && w_t) r_match <= r_match + MATCH_W'(1);
            if (w_g != w_t) r_pen   <= r_pen + PENALTY_W'(1);
        end
    end

    // score = (match << 8) / penalty, restoring, one quotient bit per cycle
    logic [QW-1:0]      r_qrem;
    logic [SW-1:0]      r_qdvs;
    logic [SCORE_W-1:0] r_q;
    logic               w_ge_q;

    assign w_ge_q = (SW'(r_qrem) >= r_qdvs);

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_load) begin
            r_qrem <= {r_match, 8'd0};
            r_qdvs <= SW'(r_pen) << (SCORE_W - 1);
            r_q    <= '0;
        end else if (i_cmd.div_step) begin
            if (w_ge_q) r_qrem <= QW'(SW'(r_qrem) - r_qdvs);
            r_q    <= {r_q[SCORE_W-2:0], w_ge_q};
            r_qdvs <= r_qdvs >> 1;
        end
    end

    // output register
    logic                 r_out_valid;
    logic [SCORE_W-1:0]   r_score_o;
    logic [MATCH_W-1:0]   r_match_o;
    logic [PENALTY_W-1:0] r_pen_o;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_score_o <= r_q;
            r_match_o <= r_match;
            r_pen_o   <= r_pen;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_score_q8      = r_score_o;
    assign o_match_count   = r_match_o;
    assign o_penalty_count = r_pen_o;

    assign o_sts.last      = r_last;
    assign o_sts.out_valid = r_out_valid;

endmodule

// ----- src/gesture_grid_template_match.sv -----
// Channel  | Dir | Handshake                  | Payload
// ---------+-----+----------------------------+---------------------------------------------
// s (in)   | in  | i_s_tvalid / o_s_tready    | tdata: x_pos, y_pos; tlast: last_point
// m (out)  | out | o_m_tvalid / i_m_tready    | tdata: score_q8, match_count, penalty_count
// cfg      | in  | i_cfg_we (no back-pressure)| i_cfg_addr: 0 canvas_size, 1 template_bits
//
// A point is accepted, then mapped to a grid cell by 4 steps of the restoring
// divider, then its cell is marked.
// A last point adds a pooling walk over the 25 2x2 blocks, the score divider
// (a load, then one quotient bit per cycle) and a load of the output register,
// which waits while the previous result is untaken.
// Reset is synchronous, active low; it clears the grid.
// A result waits in the output register while the next points are taken.
module gesture_grid_template_match #(
    parameter int COORD_BITS = ggtm_pkg::COORD_BITS_DEF,
    parameter int IN_W       = ((2 * COORD_BITS + 7) / 8) * 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input stream
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [IN_W-1:0]                 i_s_tdata,  // x_pos, y_pos, zero pad
    input  logic                            i_s_tlast,  // last_point
    // result stream
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [ggtm_pkg::OUT_W-1:0]      o_m_tdata,  // score_q8, match_count,
                                                        // penalty_count, zero pad
    // configuration writes
    input  logic                            i_cfg_we,
    input  logic [0:0]                      i_cfg_addr,
    input  logic [ggtm_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import ggtm_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    logic [SCORE_W-1:0]   w_score;
    logic [MATCH_W-1:0]   w_match;
    logic [PENALTY_W-1:0] w_pen;

    ggtm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    ggtm_dp #(
        .COORD_BITS (COORD_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_x_pos         (i_s_tdata[COORD_BITS-1:0]),
        .i_y_pos         (i_s_tdata[2*COORD_BITS-1:COORD_BITS]),
        .i_last_point    (i_s_tlast),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .o_out_valid     (o_m_tvalid),
        .i_out_ready     (i_m_tready),
        .o_score_q8      (w_score),
        .o_match_count   (w_match),
        .o_penalty_count (w_pen)
    );

    // fields packed from bit 0 up, padded to whole bytes
    assign o_m_tdata = OUT_W'({w_pen, w_match, w_score});

endmodule

// ----- src/ggtm_checker.sv -----
`include "gesture_grid_template_match_macros.svh"

module ggtm_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_s_tvalid,
    input logic                       o_s_tready,
    input logic                       o_m_tvalid,
    input logic                       i_m_tready,
    input logic [ggtm_pkg::OUT_W-1:0] o_m_tdata
);
    import ggtm_pkg::*;

    logic [MATCH_W-1:0]   w_match;
    logic [PENALTY_W-1:0] w_pen;

    assign w_match = o_m_tdata[SCORE_W +: MATCH_W];
    assign w_pen   = o_m_tdata[SCORE_W + MATCH_W +: PENALTY_W];

    // result holds until taken
    `GGTM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid)
    `GGTM_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, $stable(o_m_tdata))
    // mapping a point keeps the input closed the next cycle
    `GGTM_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready)
    // penalty starts at the base value
    `GGTM_ASSERT_SAME(a_pen_floor, i_clk, i_rst_n, o_m_tvalid, w_pen >= BASE_PENALTY)
    // matches and differences share the 25 pooled cells
    `GGTM_ASSERT_SAME(a_count_sum, i_clk, i_rst_n, o_m_tvalid, (7'(w_match) + 7'(w_pen)) <= 7'(POOL_CELLS + 8))

endmodule

bind gesture_grid_template_match ggtm_checker u_ggtm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
